[hw/rtl/arpc_pkg.sv]
// Package for the ARP cache table: shared constants, operation and status codes,
// and the entry and beat structs.
// No dependencies; compile first.
package arpc_pkg;

    // Defaults and reset values
    localparam int          NUM_ENTRIES_DEF = 8;
    localparam logic [7:0]  RELOAD_RESET    = 8'd20;
    // Group bit of the first MAC byte marks a multicast address
    localparam logic [7:0]  MCAST_MASK      = 8'h01;

    // Operation codes carried in the mode field
    localparam logic [1:0]  MODE_AGE    = 2'd0;
    localparam logic [1:0]  MODE_LOOKUP = 2'd1;
    localparam logic [1:0]  MODE_INSERT = 2'd2;

    // Insert status codes
    localparam logic [2:0]  STAT_NONE    = 3'd0;
    localparam logic [2:0]  STAT_REJECT  = 3'd1;
    localparam logic [2:0]  STAT_REFRESH = 3'd2;
    localparam logic [2:0]  STAT_PLACED  = 3'd3;
    localparam logic [2:0]  STAT_REPLACE = 3'd4;

    // One stored entry (the active bit lives in flops beside the memory)
    typedef struct packed {
        logic [7:0]  lifetime;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    // Request beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ip_address;
        logic [47:0] mac_address;
    } t_req;

    // Result beat
    typedef struct packed {
        logic        hit;
        logic [47:0] mac_out;
        logic [2:0]  insert_status;
        logic [7:0]  entry_index;
    } t_rsp;

endpackage

[hw/rtl/arpc_req_if.sv]
// Request channel of the ARP cache table: valid/ready plus request payload.
// No dependencies.
interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] ip_address;
    logic [47:0] mac_address;

    modport source (output valid, output mode, output ip_address, output mac_address,
                    input ready);
    modport sink   (input valid, input mode, input ip_address, input mac_address,
                    output ready);
endinterface

[hw/rtl/arpc_rsp_if.sv]
// Result channel of the ARP cache table: valid/ready plus result payload.
// No dependencies.
interface arpc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [47:0] mac_out;
    logic [2:0]  insert_status;
    logic [7:0]  entry_index;

    modport source (output valid, output hit, output mac_out, output insert_status,
                    output entry_index, input ready);
    modport sink   (input valid, input hit, input mac_out, input insert_status,
                    input entry_index, output ready);
endinterface

[hw/rtl/arpc_entry_ram.sv]
// Entry store of the ARP cache table: one write port, one registered read port.
// Depends on arpc_pkg (t_entry).
module arpc_entry_ram #(
    parameter int NUM_ENTRIES = arpc_pkg::NUM_ENTRIES_DEF,
    parameter int IW          = 3
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_waddr,
    input  arpc_pkg::t_entry     i_wdata,
    input  logic [IW-1:0]        i_raddr,
    output arpc_pkg::t_entry     o_rdata
);

    arpc_pkg::t_entry mem [NUM_ENTRIES];
    arpc_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/arpc_ctrl.sv]
// Sequencer of the ARP cache table: scans the entry store, ages, looks up and
// inserts, and holds the active bits. Depends on arpc_pkg.
module arpc_ctrl #(
    parameter int NUM_ENTRIES = arpc_pkg::NUM_ENTRIES_DEF,
    parameter int IW          = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  arpc_pkg::t_req       i_req,
    input  logic [7:0]           i_reload,
    output logic                 o_idle,
    output logic [IW-1:0]        o_raddr,
    input  arpc_pkg::t_entry     i_rdata,
    output logic                 o_we,
    output logic [IW-1:0]        o_waddr,
    output arpc_pkg::t_entry     o_wdata,
    input  logic                 i_res_free,
    output logic                 o_done,
    output arpc_pkg::t_rsp       o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_SCAN,
        S_RESOLVE,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_k;
    arpc_pkg::t_req       r_req;
    logic [NUM_ENTRIES-1:0] r_active;
    logic                 r_found;
    logic [IW-1:0]        r_fidx;
    logic [47:0]          r_fmac;
    logic                 r_idle_f;
    logic [IW-1:0]        r_iidx;
    logic [7:0]           r_least;
    logic [IW-1:0]        r_lidx;
    arpc_pkg::t_rsp       r_res;

    logic                 w_last;
    logic                 w_act;
    logic                 w_match;
    logic                 w_reject;
    logic                 w_ins;
    logic [IW-1:0]        w_sel;
    logic [2:0]           w_stat;

    // Entry under inspection: data for r_k arrives this cycle
    assign w_last   = (r_k == IW'(NUM_ENTRIES - 1));
    assign w_act    = r_active[r_k];
    assign w_match  = w_act && (i_rdata.ip == r_req.ip_address);
    assign w_reject = (i_req.ip_address == 32'd0) ||
                      ((i_req.mac_address[47:40] & arpc_pkg::MCAST_MASK) != 8'd0);
    assign w_ins    = (r_req.mode == arpc_pkg::MODE_INSERT);

    // Target of an insert: matching entry, else first idle, else least lifetime
    always_comb begin
        if (r_found) begin
            w_sel  = r_fidx;
            w_stat = arpc_pkg::STAT_REFRESH;
        end else if (r_idle_f) begin
            w_sel  = r_iidx;
            w_stat = arpc_pkg::STAT_PLACED;
        end else begin
            w_sel  = r_lidx;
            w_stat = arpc_pkg::STAT_REPLACE;
        end
    end

    // Read address runs one entry ahead of the inspected one
    always_comb begin
        if (r_state == S_IDLE || w_last) begin
            o_raddr = '0;
        end else begin
            o_raddr = r_k + 1'b1;
        end
    end

    // Write port: decremented lifetime while ageing, whole entry on insert
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_k;
        o_wdata = i_rdata;
        case (r_state)
            S_AGE: begin
                o_we             = w_act && (i_rdata.lifetime != 8'd0);
                o_wdata.lifetime = i_rdata.lifetime - 8'd1;
            end
            S_RESOLVE: begin
                o_we    = w_ins;
                o_waddr = w_sel;
                o_wdata = '{lifetime: i_reload, ip: r_req.ip_address,
                            mac: r_req.mac_address};
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE) && i_res_free;
    assign o_res  = r_res;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req    <= i_req;
                        r_k      <= '0;
                        r_found  <= 1'b0;
                        r_idle_f <= 1'b0;
                        r_least  <= i_reload;
                        r_lidx   <= '0;
                        case (i_req.mode)
                            arpc_pkg::MODE_AGE: begin
                                r_state <= S_AGE;
                            end
                            arpc_pkg::MODE_LOOKUP: begin
                                r_state <= S_SCAN;
                            end
                            arpc_pkg::MODE_INSERT: begin
                                if (w_reject) begin
                                    r_res   <= '{hit: 1'b0, mac_out: '0,
                                                 insert_status: arpc_pkg::STAT_REJECT,
                                                 entry_index: '0};
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_AGE: begin
                    // expired entries go idle; others are rewritten via the write port
                    if (w_act && (i_rdata.lifetime == 8'd0)) begin
                        r_active[r_k] <= 1'b0;
                    end
                    r_k <= r_k + 1'b1;
                    if (w_last) begin
                        r_res   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_k;
                        r_fmac  <= i_rdata.mac;
                    end
                    if (!w_act && !r_idle_f) begin
                        r_idle_f <= 1'b1;
                        r_iidx   <= r_k;
                    end
                    if (w_act && (i_rdata.lifetime < r_least)) begin
                        r_least <= i_rdata.lifetime;
                        r_lidx  <= r_k;
                    end
                    r_k <= r_k + 1'b1;
                    if (w_last) begin
                        r_state <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    if (w_ins) begin
                        r_active[w_sel] <= 1'b1;
                        r_res <= '{hit: 1'b0, mac_out: '0, insert_status: w_stat,
                                   entry_index: 8'(w_sel)};
                    end else begin
                        r_res <= '{hit: r_found,
                                   mac_out: r_found ? r_fmac : 48'd0,
                                   insert_status: arpc_pkg::STAT_NONE,
                                   entry_index: r_found ? 8'(r_fidx) : 8'd0};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Store is written only while ageing or resolving an insert
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_AGE || r_state == S_RESOLVE))
        else $error("entry store written outside ageing or insert");

    // An inserted entry is active afterwards
    a_ins_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE && w_ins) |=> r_active[$past(w_sel)])
        else $error("inserted entry not marked active");

    // A lookup hit always points at an active entry
    a_hit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE && !w_ins && r_found) |-> r_active[r_fidx])
        else $error("lookup hit on an idle entry");

    // Sequencer leaves idle only on an accepted beat
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> (r_state == S_IDLE))
        else $error("sequencer left idle without a request");

endmodule

[hw/rtl/arp_cache_table_core.sv]
// Top level of the ARP cache table: lifetime register, entry store, sequencer
// and result register. Depends on arpc_pkg, arpc_req_if, arpc_rsp_if,
// arpc_entry_ram and arpc_ctrl.
//
//  Channel   Dir  Handshake          Payload
//  i_req     in   valid/ready        mode, ip_address, mac_address
//  o_rsp     out  valid/ready        hit, mac_out, insert_status, entry_index
//  i_cfg     in   i_cfg_we           i_cfg_wdata (lifetime_reload)
//
// Each operation is one scan of the entry store, one entry per cycle through its
// single read port; lookup and insert then pass through a resolve step, ageing does
// not, and a rejected insert or unused mode skips the scan and goes straight to done.
// A new beat is taken in the cycle after the result is handed to the output register.
// Reset clears the active bits; no clearing pass over the store.
// A result waiting in o_rsp holds the sequencer in its final state until taken.
module arp_cache_table_core #(
    parameter int NUM_ENTRIES = arpc_pkg::NUM_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    arpc_req_if.sink      i_req,
    arpc_rsp_if.source    o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [7:0]           r_lifetime_reload;
    logic                 r_out_valid;
    arpc_pkg::t_rsp       r_out;

    logic                 w_idle;
    logic                 w_start;
    logic                 w_done;
    logic                 w_res_free;
    arpc_pkg::t_req       w_req;
    arpc_pkg::t_rsp       w_res;
    logic [IW-1:0]        w_raddr;
    logic [IW-1:0]        w_waddr;
    logic                 w_we;
    arpc_pkg::t_entry     w_wdata;
    arpc_pkg::t_entry     w_rdata;

    // Lifetime reload register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime_reload <= arpc_pkg::RELOAD_RESET;
        end else if (i_cfg_we) begin
            r_lifetime_reload <= i_cfg_wdata;
        end
    end

    // Request side
    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;
    assign w_req       = '{mode: i_req.mode, ip_address: i_req.ip_address,
                           mac_address: i_req.mac_address};

    arpc_entry_ram #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IW          (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    arpc_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IW          (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (w_req),
        .i_reload   (r_lifetime_reload),
        .o_idle     (w_idle),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .i_res_free (w_res_free),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    // Result register
    assign w_res_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.mac_out       = r_out.mac_out;
    assign o_rsp.insert_status = r_out.insert_status;
    assign o_rsp.entry_index   = r_out.entry_index;

    // User writes configuration only with no beat in flight; not enforced by block.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (w_idle && !r_out_valid))
        else $error("lifetime reload written while a beat is in flight");

endmodule

[tb/arp_cache_table_core_tb.sv]
// Testbench for arp_cache_table_core: directed and random request streams with
// a cycle-free cache predictor checking every result beat.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if and the RTL of the block.
`timescale 1ns / 100ps

module arp_cache_table_core_tb;

    localparam int         N_ENTRIES  = arpc_pkg::NUM_ENTRIES_DEF;
    localparam int         SCAN_LAT   = N_ENTRIES + 4;
    // Mode code with no operation behind it
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    arpc_req_if req_if();
    arpc_rsp_if rsp_if();

    arp_cache_table_core #(
        .NUM_ENTRIES (N_ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predicted cache contents
    bit          cache_active [N_ENTRIES];
    logic [7:0]  cache_life   [N_ENTRIES];
    logic [31:0] cache_ip     [N_ENTRIES];
    logic [47:0] cache_mac    [N_ENTRIES];
    logic [7:0]  life_reload;

    arpc_pkg::t_rsp due_replies [$];
    int          mismatch_count;
    bit          no_idle;
    int          ready_wait;
    int          hold_off_len;
    logic [31:0] ip_pool [12];

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Run limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Apply one operation to the predicted cache and return the expected beat
    function automatic arpc_pkg::t_rsp apply_cache_op(input arpc_pkg::t_req r);
        arpc_pkg::t_rsp res;
        bit         found;
        int         slot;
        int         least_at;
        logic [7:0] least;
        res   = '0;
        found = 1'b0;
        case (r.mode)
            arpc_pkg::MODE_AGE: begin
                for (int k = 0; k < N_ENTRIES; k++) begin
                    if (cache_active[k]) begin
                        if (cache_life[k] != 8'd0)
                            cache_life[k] = cache_life[k] - 8'd1;
                        else
                            cache_active[k] = 1'b0;
                    end
                end
            end
            arpc_pkg::MODE_LOOKUP: begin
                for (int k = 0; k < N_ENTRIES; k++) begin
                    if (!found && cache_active[k] && cache_ip[k] == r.ip_address) begin
                        found             = 1'b1;
                        res.hit           = 1'b1;
                        res.mac_out       = cache_mac[k];
                        res.entry_index   = 8'(k);
                    end
                end
            end
            arpc_pkg::MODE_INSERT: begin
                if (r.ip_address == 32'd0 ||
                    (r.mac_address[47:40] & arpc_pkg::MCAST_MASK) != 8'd0) begin
                    res.insert_status = arpc_pkg::STAT_REJECT;
                end else begin
                    // refresh a live entry with the same address
                    for (int k = 0; k < N_ENTRIES; k++) begin
                        if (!found && cache_active[k] && cache_ip[k] == r.ip_address) begin
                            found             = 1'b1;
                            cache_mac[k]      = r.mac_address;
                            cache_life[k]     = life_reload;
                            res.insert_status = arpc_pkg::STAT_REFRESH;
                            res.entry_index   = 8'(k);
                        end
                    end
                    if (!found) begin
                        // first idle slot, else the shortest remaining lifetime
                        least    = life_reload;
                        least_at = 0;
                        slot     = -1;
                        for (int k = 0; k < N_ENTRIES; k++) begin
                            if (slot < 0) begin
                                if (!cache_active[k]) begin
                                    slot = k;
                                end else if (cache_life[k] < least) begin
                                    least    = cache_life[k];
                                    least_at = k;
                                end
                            end
                        end
                        if (slot >= 0) begin
                            res.insert_status = arpc_pkg::STAT_PLACED;
                        end else begin
                            slot              = least_at;
                            res.insert_status = arpc_pkg::STAT_REPLACE;
                        end
                        cache_active[slot] = 1'b1;
                        cache_life[slot]   = life_reload;
                        cache_ip[slot]     = r.ip_address;
                        cache_mac[slot]    = r.mac_address;
                        res.entry_index    = 8'(slot);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request beat; valid stays high when the next gap is zero
    task automatic send_beat(input arpc_pkg::t_req r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.mode        = r.mode;
        req_if.ip_address  = r.ip_address;
        req_if.mac_address = r.mac_address;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        due_replies.push_back(apply_cache_op(r));
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [1:0] mode, input logic [31:0] ip,
                           input logic [47:0] mac);
        arpc_pkg::t_req r;
        r.mode        = mode;
        r.ip_address  = ip;
        r.mac_address = mac;
        send_beat(r);
    endtask

    // Wait for every expected beat, let the sequencer settle
    task automatic drain_all();
        req_if.valid = 1'b0;
        while (due_replies.size() != 0)
            @(posedge i_clk);
        repeat (SCAN_LAT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reload(input logic [7:0] value);
        drain_all();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        life_reload = value;
    endtask

    task automatic refill_pool();
        foreach (ip_pool[k]) begin
            ip_pool[k] = $urandom;
            if (ip_pool[k] == 32'd0)
                ip_pool[k] = 32'h0A00_0001;
        end
    endtask

    // Mostly well-formed traffic over a small address pool, some noise
    function automatic arpc_pkg::t_req random_req();
        arpc_pkg::t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.mode = arpc_pkg::MODE_INSERT;
        else if (pick < 75)
            r.mode = arpc_pkg::MODE_LOOKUP;
        else if (pick < 96)
            r.mode = arpc_pkg::MODE_AGE;
        else
            r.mode = MODE_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            r.ip_address = ip_pool[$urandom_range(0, 11)];
        else if (pick < 90)
            r.ip_address = 32'd0;
        else
            r.ip_address = $urandom;
        r.mac_address = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0)
            r.mac_address[40] = 1'b0;
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        arpc_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            ready_wait = draw_gap();
            if (due_replies.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = due_replies.pop_front();
                if (rsp_if.hit !== want.hit) begin
                    $error("hit: expected %0h, got %0h", want.hit, rsp_if.hit);
                    mismatch_count++;
                end
                if (rsp_if.mac_out !== want.mac_out) begin
                    $error("mac_out: expected %0h, got %0h", want.mac_out, rsp_if.mac_out);
                    mismatch_count++;
                end
                if (rsp_if.insert_status !== want.insert_status) begin
                    $error("insert_status: expected %0d, got %0d",
                           want.insert_status, rsp_if.insert_status);
                    mismatch_count++;
                end
                if (rsp_if.entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, rsp_if.entry_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Result ready: per-beat stall, plus a long hold-off when one is set
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len > 0) begin
                rsp_if.ready = 1'b0;
                repeat (hold_off_len) @(negedge i_clk);
                hold_off_len = 0;
            end else if (ready_wait > 0) begin
                rsp_if.ready = 1'b0;
                ready_wait--;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Empty cache, rejects, fill, refresh and replacement order
    task automatic test_basic_ops();
        send_op(arpc_pkg::MODE_LOOKUP, 32'd0, 48'd0);
        send_op(arpc_pkg::MODE_AGE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_op(MODE_SPARE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_op(arpc_pkg::MODE_INSERT, 32'd0, 48'h0200_0000_0001);
        send_op(arpc_pkg::MODE_INSERT, 32'h0A00_0001, 48'h0100_0000_0000);
        send_op(arpc_pkg::MODE_INSERT, 32'hFFFF_FFFF, 48'hFEFF_FFFF_FFFF);
        send_op(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 48'd0);
        send_op(arpc_pkg::MODE_INSERT, 32'hFFFF_FFFF, 48'd0);
        send_op(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        for (int k = 1; k < N_ENTRIES; k++)
            send_op(arpc_pkg::MODE_INSERT, 32'(k), 48'h0200_0000_0000 + 48'(k));
        // full, all at reload: entry 0 goes
        send_op(arpc_pkg::MODE_INSERT, 32'd8, 48'h0A0B_0C0D_0E0F);
        send_op(arpc_pkg::MODE_AGE, 32'd0, 48'd0);
        send_op(arpc_pkg::MODE_INSERT, 32'd2, 48'h0000_0000_0002);
        // ties at the shortest lifetime go to the lowest index
        send_op(arpc_pkg::MODE_INSERT, 32'd9, 48'h0000_0000_0009);
        send_op(arpc_pkg::MODE_INSERT, 32'd10, 48'h0000_0000_000A);
    endtask

    // Expiry at reload zero and replacement at the largest reload
    task automatic test_expiry();
        set_reload(8'd0);
        send_op(arpc_pkg::MODE_INSERT, 32'hC0A8_0001, 48'h0011_2233_4455);
        send_op(arpc_pkg::MODE_AGE, 32'd0, 48'd0);
        send_op(arpc_pkg::MODE_LOOKUP, 32'hC0A8_0001, 48'd0);
        send_op(arpc_pkg::MODE_INSERT, 32'hC0A8_0002, 48'h0066_7788_99AA);
        set_reload(8'd255);
        send_op(arpc_pkg::MODE_INSERT, 32'hC0A8_0003, 48'h00BB_CCDD_EEFF);
    endtask

    // Hold the result side off long enough for the input to stall
    task automatic test_backpressure();
        drain_all();
        refill_pool();
        no_idle      = 1'b1;
        hold_off_len = 300;
        repeat (30) send_beat(random_req());
        no_idle = 1'b0;
    endtask

    // Random phases across several reload values
    task automatic test_random_traffic();
        logic [7:0] reloads [6];
        reloads = '{8'd20, 8'd3, 8'd255, 8'd0, 8'd1, 8'd0};
        reloads[5] = 8'($urandom_range(0, 255));
        foreach (reloads[p]) begin
            set_reload(reloads[p]);
            refill_pool();
            for (int chunk = 0; chunk < 7; chunk++) begin
                no_idle = ($urandom_range(0, 3) == 0);
                repeat (40) send_beat(random_req());
            end
            no_idle = 1'b0;
        end
    endtask

    // Sequence
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'd0;
        req_if.valid       = 1'b0;
        req_if.mode        = arpc_pkg::MODE_AGE;
        req_if.ip_address  = 32'd0;
        req_if.mac_address = 48'd0;
        mismatch_count     = 0;
        no_idle            = 1'b0;
        ready_wait         = 0;
        hold_off_len       = 0;
        life_reload        = arpc_pkg::RELOAD_RESET;
        for (int k = 0; k < N_ENTRIES; k++) begin
            cache_active[k] = 1'b0;
            cache_life[k]   = 8'd0;
            cache_ip[k]     = 32'd0;
            cache_mac[k]    = 48'd0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_expiry();
        test_backpressure();
        test_random_traffic();

        drain_all();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
